[rtl/core/tpas_pkg.sv]
`default_nettype none

package tpas_pkg;

  // Field and register widths
  localparam int PERIOD_W = 32;
  localparam int CLK_HZ_W = 29;
  localparam int SPEED_W = 32;

  // Ring geometry: depth is a power of two so the average is a plain shift
  localparam int RING_LOG2 = 3;
  localparam int RING_DEPTH = 1 << RING_LOG2;
  localparam int SUM_W = PERIOD_W + RING_LOG2;

  // Divider geometry: the numerator is ten times the clock frequency
  localparam int NUM_W = CLK_HZ_W + 4;
  localparam int DEN_W = SUM_W - RING_LOG2;
  localparam int STEP_W = $clog2(NUM_W + 1);

  // Stream payload widths, padded to whole bytes
  localparam int OUT_BITS = SPEED_W + PERIOD_W + SUM_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] RELOAD_RESET = PERIOD_W'(80000000);
  localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = CLK_HZ_W'(80000000);

  // Configuration register indexes
  localparam logic REG_TIMER_RELOAD = 1'b0;
  localparam logic REG_CLOCK_HZ = 1'b1;

  // Input item kinds
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RING,
    ST_START,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

`default_nettype wire

[rtl/core/tpas_ring.sv]
`default_nettype none

module tpas_ring
  import tpas_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic [PERIOD_W-1:0] period,
  output logic      [SUM_W-1:0]    sum
);

  logic [PERIOD_W-1:0]  entries [RING_DEPTH];
  logic [RING_LOG2-1:0] wr_idx;
  logic [SUM_W-1:0]     sum_next;

  // Drop the oldest period and add the new one.
  assign sum_next = sum - SUM_W'(entries[wr_idx]) + SUM_W'(period);

  // Ring storage, running sum and write pointer; the pointer wraps naturally.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        entries[i] <= '0;
      end
      sum <= '0;
      wr_idx <= '0;
    end else if (wr_en) begin
      entries[wr_idx] <= period;
      sum <= sum_next;
      wr_idx <= wr_idx + 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tpas_div.sv]
`default_nettype none

module tpas_div
  import tpas_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic      [NUM_W-1:0] quotient
);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DEN_W:0]    trial;
  logic              fits;
  logic [DEN_W:0]    diff;

  // One restoring step: bring down the next numerator bit and try a subtract.
  assign trial = {rem, quotient[NUM_W-1]};
  assign fits = trial >= {1'b0, den};
  assign diff = trial - {1'b0, den};

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator shifts out while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[rtl/core/tach_period_average_speed.sv]
// A result is offered from the output register once its word has been taken, written into the ring
// and divided: the sequencer takes the word, updates the ring, starts the shared restoring divider,
// waits for its 33 steps and loads the result before the next word is taken.
// The input is not ready during reset or while a word is in flight; a finished result waits
// in the output register, so the next word is taken while it is held.
// Synchronous reset clears the ring, sum and write pointer and loads both registers with 80000000.
`default_nettype none

module tach_period_average_speed
  import tpas_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Configuration write port
  input  wire logic                   cfg_write,
  input  wire logic                   cfg_index,
  input  wire logic [PERIOD_W-1:0]    cfg_data,
  // Input stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [PERIOD_W-1:0]    s_tdata,   // [31:0] timer_count
  input  wire logic                   s_tuser,   // [0] func
  // Output stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [31:0] speed_tenths, [63:32] captured_period, [98:64] period_total, rest zero
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  state_t                state;
  state_t                state_next;
  logic [PERIOD_W-1:0]   timer_reload;
  logic [CLK_HZ_W-1:0]   clock_hz;
  logic [PERIOD_W-1:0]   period;
  logic [PERIOD_W-1:0]   period_next;
  logic [SUM_W-1:0]      sum;
  logic [NUM_W-1:0]      numerator;
  logic [DEN_W-1:0]      average;
  logic [NUM_W-1:0]      quotient;
  logic [SPEED_W-1:0]    speed;
  logic                  div_done;
  logic                  ring_wr;
  logic                  div_start;
  logic                  out_free;
  logic                  out_load;
  logic                  accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_reload <= RELOAD_RESET;
      clock_hz <= CLK_HZ_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIMER_RELOAD: timer_reload <= cfg_data;
        REG_CLOCK_HZ:     clock_hz <= cfg_data[CLK_HZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  // Period of the incoming word; a late capture or a timeout gives zero.
  always_comb begin
    period_next = '0;
    if (s_tuser == FUNC_EDGE && s_tdata <= timer_reload) begin
      period_next = timer_reload - s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      period <= period_next;
    end
  end

  tpas_ring u_ring (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (ring_wr),
    .period (period),
    .sum    (sum)
  );

  // Ten times the clock frequency as 8x + 2x; average is the sum over the depth.
  assign numerator = (NUM_W'(clock_hz) << 3) + (NUM_W'(clock_hz) << 1);
  assign average = sum[SUM_W-1:RING_LOG2];

  tpas_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (numerator),
    .divisor  (average),
    .done     (div_done),
    .quotient (quotient)
  );

  // Zero average gives zero speed; a quotient beyond 32 bits saturates.
  always_comb begin
    if (average == '0) begin
      speed = '0;
    end else if (quotient[NUM_W-1:SPEED_W] != '0) begin
      speed = '1;
    end else begin
      speed = quotient[SPEED_W-1:0];
    end
  end

  assign out_free = !m_tvalid || m_tready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_RING;
        end
      end
      ST_RING:  state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs; no word is taken while reset is applied.
  always_comb begin
    s_tready = 1'b0;
    ring_wr = 1'b0;
    div_start = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:  s_tready = !rst;
      ST_RING:  ring_wr = 1'b1;
      ST_START: div_start = 1'b1;
      ST_DIV:   out_load = div_done && out_free;
      ST_HOLD:  out_load = out_free;
      default: ;
    endcase
  end

  // Output register decouples the result from the next word's work.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'({sum, period, speed});
    end
  end

  // A word taken in always moves on to the ring update.
  assert property (@(posedge clk) disable iff (rst) accept |=> state == ST_RING)
    else $error("accepted word did not start the ring update");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == ST_DIV)
    else $error("divider completed outside the divide state");

  // Holding a result happens only while the previous one is still unread.
  assert property (@(posedge clk) disable iff (rst) state == ST_HOLD |-> m_tvalid)
    else $error("result held although the output register is free");

  // A result is loaded only when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !out_load)
    else $error("result loaded over an unread result");

endmodule

`default_nettype wire

[bench/tach_period_average_speed_test.sv]
`timescale 1ns / 100ps

module tach_period_average_speed_test;
  import tpas_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 78;
  localparam int PERIOD_LO = SPEED_W;
  localparam int TOTAL_LO = SPEED_W + PERIOD_W;

  // Tracks the ring, the running sum and the registers, and keeps the
  // expected words in arrival order.
  class tach_speed_tracker;
    logic [PERIOD_W-1:0] ring [RING_DEPTH];
    logic [SUM_W-1:0]    total;
    logic [RING_LOG2-1:0] slot;
    logic [PERIOD_W-1:0] reload;
    logic [CLK_HZ_W-1:0] clk_hz;
    logic [SPEED_W-1:0]  speed_q [$];
    logic [PERIOD_W-1:0] period_q [$];
    logic [SUM_W-1:0]    total_q [$];
    int errors;
    int words_in;
    int words_out;
    int timeouts;
    int clamps;
    int zero_speeds;
    int saturations;

    function new();
      foreach (ring[i]) ring[i] = '0;
      total = '0;
      slot = '0;
      reload = RELOAD_RESET;
      clk_hz = CLK_HZ_RESET;
      errors = 0;
      words_in = 0;
      words_out = 0;
      timeouts = 0;
      clamps = 0;
      zero_speeds = 0;
      saturations = 0;
    endfunction

    function void set_reg(logic idx, logic [PERIOD_W-1:0] data);
      if (idx == REG_TIMER_RELOAD) begin
        reload = data;
      end else begin
        clk_hz = data[CLK_HZ_W-1:0];
      end
    endfunction

    function int pending();
      return speed_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    // Insert the new period, update the sum and predict the speed.
    function void note_word(logic func, logic [PERIOD_W-1:0] count);
      logic [PERIOD_W-1:0] period;
      longint unsigned avg;
      longint unsigned speed;
      period = '0;
      if (func == FUNC_TIMEOUT) begin
        timeouts++;
      end else if (count <= reload) begin
        period = reload - count;
      end else begin
        clamps++;
      end
      total = total - SUM_W'(ring[slot]) + SUM_W'(period);
      ring[slot] = period;
      slot = slot + 1'b1;
      avg = longint'(total) >> RING_LOG2;
      speed = 0;
      if (avg != 0) begin
        speed = (64'(clk_hz) * 64'd10) / avg;
        if (speed > 64'hFFFF_FFFF) begin
          speed = 64'hFFFF_FFFF;
          saturations++;
        end
      end
      if (speed == 0) zero_speeds++;
      speed_q.push_back(speed[SPEED_W-1:0]);
      period_q.push_back(period);
      total_q.push_back(total);
      words_in++;
    endfunction

    // Compare one output word with the oldest expectation.
    task check_word(logic [OUT_TDATA_W-1:0] w);
      logic [SPEED_W-1:0] e_speed;
      logic [PERIOD_W-1:0] e_period;
      logic [SUM_W-1:0] e_total;
      words_out++;
      if (speed_q.size() == 0) begin
        report($sformatf("output word %0d arrived with nothing expected", words_out));
      end else begin
        e_speed = speed_q.pop_front();
        e_period = period_q.pop_front();
        e_total = total_q.pop_front();
        if (w[SPEED_W-1:0] !== e_speed)
          report($sformatf("word %0d speed_tenths %0d, expected %0d",
                           words_out, w[SPEED_W-1:0], e_speed));
        if (w[PERIOD_LO +: PERIOD_W] !== e_period)
          report($sformatf("word %0d captured_period %0d, expected %0d",
                           words_out, w[PERIOD_LO +: PERIOD_W], e_period));
        if (w[TOTAL_LO +: SUM_W] !== e_total)
          report($sformatf("word %0d period_total %0d, expected %0d",
                           words_out, w[TOTAL_LO +: SUM_W], e_total));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_TIMER_RELOAD;
  logic [PERIOD_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [PERIOD_W-1:0] s_tdata = '0;
  logic s_tuser = FUNC_EDGE;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  tach_speed_tracker tracker = new();
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_hold_req = 1'b0;
  int cycle_count = 0;

  tach_period_average_speed DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Output side: random stalls, one long hold-off on request.
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.check_word(m_tdata);
    end
  end

  task automatic write_reg(input logic idx, input logic [PERIOD_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    tracker.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Offer one word after a random gap and wait for it to be taken.
  task automatic send_word(input logic func, input logic [PERIOD_W-1:0] count);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= count;
    do @(posedge clk); while (!s_tready);
    tracker.note_word(func, count);
  endtask

  // Stop offering, wait for every result, then let the pipeline settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly in-range captures with periods up to span, plus timeouts,
  // arbitrary counts and counts above the reload value.
  task automatic random_phase(input int n_items, input longint unsigned span);
    int r;
    longint unsigned rl;
    longint unsigned p;
    logic [PERIOD_W-1:0] count;
    rl = longint'(tracker.reload);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_word(FUNC_TIMEOUT, $urandom);
      end else if (r < 22) begin
        send_word(FUNC_EDGE, $urandom);
      end else if (r < 30 && rl != 64'hFFFF_FFFF) begin
        p = longint'($urandom) % (64'hFFFF_FFFF - rl);
        count = PERIOD_W'(rl + 1 + p);
        send_word(FUNC_EDGE, count);
      end else begin
        p = longint'($urandom) % (span + 1);
        if (p > rl) p = rl;
        count = PERIOD_W'(rl - p);
        send_word(FUNC_EDGE, count);
      end
      if ($urandom_range(0, 19) == 0) tx_quiet = ~tx_quiet;
      if ($urandom_range(0, 19) == 0) rx_quiet = ~rx_quiet;
    end
  endtask

  initial begin
    logic [PERIOD_W-1:0] ph_reload;
    logic [PERIOD_W-1:0] ph_clk;
    longint unsigned ph_span;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: empty ring, count extremes, clamping, index wrap.
    send_word(FUNC_TIMEOUT, 32'hFFFF_FFFF);
    send_word(FUNC_EDGE, 32'h0000_0000);
    send_word(FUNC_EDGE, RELOAD_RESET);
    send_word(FUNC_EDGE, RELOAD_RESET + 1);
    send_word(FUNC_EDGE, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_word(FUNC_EDGE, $urandom_range(0, 80000000));
    send_word(FUNC_TIMEOUT, 32'h0000_0000);
    drain();

    // Largest reload and clock; the upper data bits of clock_hz are dropped.
    write_reg(REG_TIMER_RELOAD, 32'hFFFF_FFFF);
    write_reg(REG_CLOCK_HZ, 32'hFFFF_FFFF);
    for (int i = 0; i < RING_DEPTH; i++) send_word(FUNC_EDGE, 32'h0000_0000);
    drain();

    // Reload of one: the ring refills with periods of one, the average falls to one and the quotient saturates.
    write_reg(REG_TIMER_RELOAD, 32'h0000_0001);
    for (int i = 0; i < RING_DEPTH; i++) send_word(FUNC_EDGE, 32'h0000_0000);
    drain();

    // Random phases over a range of register settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin ph_reload = RELOAD_RESET; ph_clk = CLK_HZ_RESET; ph_span = 64'd1 << 20; end
        1: begin ph_reload = 32'd1; ph_clk = 32'd1; ph_span = 64'd1; end
        2: begin ph_reload = 32'hFFFF_FFFF; ph_clk = 32'd400000000; ph_span = 64'hFFFF_FFFF; end
        3: begin ph_reload = 32'd1000; ph_clk = $urandom_range(1, 400000000); ph_span = 64'd255; end
        4: begin ph_reload = $urandom; ph_clk = $urandom; ph_span = 64'd65535; end
        default: begin
          ph_reload = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 100000);
          ph_clk = $urandom_range(1, 400000000);
          case ($urandom_range(0, 3))
            0: ph_span = 64'd15;
            1: ph_span = 64'd4095;
            2: ph_span = 64'd1 << 24;
            default: ph_span = 64'hFFFF_FFFF;
          endcase
        end
      endcase
      write_reg(REG_TIMER_RELOAD, ph_reload);
      write_reg(REG_CLOCK_HZ, ph_clk);
      tx_quiet = $urandom_range(0, 2) == 0;
      rx_quiet = $urandom_range(0, 2) == 0;
      // The output side holds off long enough for the input to back up.
      if (ph == 3) begin
        tx_quiet = 1'b1;
        rx_hold_req = 1'b1;
      end
      random_phase(PHASE_ITEMS, ph_span);
      drain();
    end

    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));
    $display("covered %0d words in, %0d out: %0d timeouts, %0d clamped counts",
             tracker.words_in, tracker.words_out, tracker.timeouts, tracker.clamps);
    $display("zero speeds %0d, saturated speeds %0d, over %0d cycles",
             tracker.zero_speeds, tracker.saturations, cycle_count);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tpas_pkg.sv
rtl/core/tpas_ring.sv
rtl/core/tpas_div.sv
rtl/core/tach_period_average_speed.sv
bench/tach_period_average_speed_test.sv
